@@ rtl/dpt_pkg.sv @@
// ============================================================================
// dpt_pkg - shared types and constants for the demand paging translator
// Address split, item structs, command codes and controller/datapath links.
// ============================================================================
package dpt_pkg;

    // Address geometry: page number above, byte offset below
    localparam int ADDR_W     = 16;
    localparam int OFFSET_W   = 8;
    localparam int PAGE_W     = ADDR_W - OFFSET_W;
    localparam int PAGE_COUNT = 2 ** PAGE_W;
    localparam int PAGE_BYTES = 2 ** OFFSET_W;
    localparam int STORE_W    = PAGE_W + OFFSET_W;
    localparam int STORE_BYTES = 2 ** STORE_W;
    localparam int DATA_W     = 8;

    // Item command codes
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_XLATE = 1'b1;

    typedef struct packed {
        logic              cmd;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] data;
    } t_in_item;

    typedef struct packed {
        logic [ADDR_W-1:0]        logical_address;
        logic [ADDR_W-1:0]        physical_address;
        logic signed [DATA_W-1:0] value;
        logic                     page_fault;
    } t_out_item;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic check;
        logic copy_rd;
        logic read;
        logic resp;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic hit;
        logic copy_last;
        logic out_free;
    } t_dp_status;

endpackage

@@ rtl/dpt_datapath.sv @@
// ============================================================================
// dpt_datapath - page table, backing store, frame memory and result register
// Executes the commands of the controller one step per cycle.
// ============================================================================
module dpt_datapath
    import dpt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_cmd    i_cmd,
    input  t_in_item   i_in_item,
    input  logic       i_out_stall,
    output t_dp_status o_status,
    output logic       o_out_valid,
    output t_out_item  o_out_item
);

    // Memories
    logic [PAGE_W-1:0] pt_mem [PAGE_COUNT];
    logic [DATA_W-1:0] bs_mem [STORE_BYTES];
    logic [DATA_W-1:0] fm_mem [STORE_BYTES];

    // Control registers
    logic [PAGE_COUNT-1:0] r_pt_valid;
    logic [PAGE_W-1:0]     r_next_frame;
    logic                  r_wr_pend;
    logic                  r_out_valid;

    // Payload registers
    logic [ADDR_W-1:0]   r_addr;
    logic [PAGE_W-1:0]   r_pt_rdata;
    logic [PAGE_W-1:0]   r_frame;
    logic                r_fault;
    logic [OFFSET_W-1:0] r_cnt;
    logic [OFFSET_W-1:0] r_wr_idx;
    logic [DATA_W-1:0]   r_bs_rdata;
    logic [DATA_W-1:0]   r_fm_rdata;
    t_out_item           r_out_item;

    logic [PAGE_W-1:0]   page;
    logic [OFFSET_W-1:0] offset;
    logic [PAGE_W-1:0]   in_page;
    logic                hit;

    assign page    = r_addr[ADDR_W-1:OFFSET_W];
    assign offset  = r_addr[OFFSET_W-1:0];
    assign in_page = i_in_item.address[ADDR_W-1:OFFSET_W];
    assign hit     = r_pt_valid[page];

    // Store a loaded byte; read backing store during a page copy
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture && i_in_item.cmd == CMD_LOAD) begin
            bs_mem[i_in_item.address] <= i_in_item.data;
        end
        if (i_cmd.copy_rd) begin
            r_bs_rdata <= bs_mem[{page, r_cnt}];
        end
    end

    // Write copied bytes in the cycle after their read; read the translated byte
    always_ff @(posedge i_clk) begin
        if (r_wr_pend) begin
            fm_mem[{r_frame, r_wr_idx}] <= r_bs_rdata;
        end
        if (i_cmd.read) begin
            r_fm_rdata <= fm_mem[{r_frame, offset}];
        end
    end

    // Page table entry: read on capture, fill on a fault
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_pt_rdata <= pt_mem[in_page];
        end
        if (i_cmd.check && !hit) begin
            pt_mem[page] <= r_next_frame;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_addr <= i_in_item.address;
        end
        if (i_cmd.check) begin
            r_frame <= hit ? r_pt_rdata : r_next_frame;
            r_fault <= !hit;
            r_cnt   <= '0;
        end else if (i_cmd.copy_rd) begin
            r_cnt <= r_cnt + 1'b1;
        end
        if (i_cmd.copy_rd) begin
            r_wr_idx <= r_cnt;
        end
        if (i_cmd.resp) begin
            r_out_item.logical_address  <= r_addr;
            r_out_item.physical_address <= {r_frame, offset};
            r_out_item.value            <= r_fm_rdata;
            r_out_item.page_fault       <= r_fault;
        end
    end

    // Control state: valid bits, frame allocator, write pending, result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pt_valid   <= '0;
            r_next_frame <= '0;
            r_wr_pend    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.check && !hit) begin
                r_pt_valid[page] <= 1'b1;
                r_next_frame     <= r_next_frame + 1'b1;
            end
            r_wr_pend <= i_cmd.copy_rd;
            if (i_cmd.resp) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.hit       = hit;
    assign o_status.copy_last = (r_cnt == {OFFSET_W{1'b1}});
    assign o_status.out_free  = !r_out_valid || !i_out_stall;
    assign o_out_valid        = r_out_valid;
    assign o_out_item         = r_out_item;

endmodule

@@ rtl/dpt_ctrl.sv @@
// ============================================================================
// dpt_ctrl - sequencing state machine of the translator
// Accepts items, walks lookup, page copy, read and result hand-off.
// ============================================================================
module dpt_ctrl
    import dpt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_is_xlate,
    input  t_dp_status i_status,
    output logic       o_in_stall,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_COPY,
        S_DRAIN,
        S_READ,
        S_RESP
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && (r_state == S_IDLE);

    // Decode commands and next state
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.capture = accept;
                if (accept && i_in_is_xlate) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                n_state     = i_status.hit ? S_READ : S_COPY;
            end
            S_COPY: begin
                o_cmd.copy_rd = 1'b1;
                if (i_status.copy_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_READ;
            end
            S_READ: begin
                o_cmd.read = 1'b1;
                n_state    = S_RESP;
            end
            S_RESP: begin
                if (i_status.out_free) begin
                    o_cmd.resp = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ rtl/demand_paging_translator_top.sv @@
// A load item gives no result and leaves the block idle, ready for the next item.
// A translate hit passes the check, read and result states; no new item is taken until
// its result is handed off. A page fault adds the page copy and a drain state, one byte
// a cycle through the single read port of the backing store.
// Reset (synchronous, active low) marks all page-table entries invalid and
// restarts frame allocation at zero; memory contents are kept.
// ============================================================================
// demand_paging_translator_top - demand-paged address translator
// Loads backing-store bytes and translates logical addresses, copying a page
// into the next free frame on a fault.
// ============================================================================
module demand_paging_translator_top
    import dpt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    dpt_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_is_xlate (i_in_item.cmd == CMD_XLATE),
        .i_status      (dp_status),
        .o_in_stall    (o_in_stall),
        .o_cmd         (dp_cmd)
    );

    dpt_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .i_in_item   (i_in_item),
        .i_out_stall (i_out_stall),
        .o_status    (dp_status),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

@@ tb/sv/demand_paging_translator_top_test.sv @@
// ============================================================================
// demand_paging_translator_top_test - self-checking bench for the translator
// Fills whole pages of the backing store with load items, then translates
// addresses into those pages. A scoreboard class mirrors the page table, the
// frame allocator and both memories, and compares every result item field by
// field. Both sides idle and stall at random.
// ============================================================================
module demand_paging_translator_top_test;
    import dpt_pkg::*;

    localparam int HALF_PERIOD    = 5;
    localparam int RESET_CYCLES   = 8;
    localparam int MAX_GAP        = 13;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_ITEMS   = 940;
    localparam int RANDOM_FILLS   = 3;
    localparam int TAIL_CYCLES    = 20;

    // ------------------------------------------------------------------------
    // Mirror of the translator: page table, frame allocator, both memories
    // ------------------------------------------------------------------------
    class xlate_scoreboard;
        logic [DATA_W-1:0] backing[STORE_BYTES];
        bit                written[STORE_BYTES];
        int unsigned       page_fill[PAGE_COUNT];
        logic [DATA_W-1:0] frames[STORE_BYTES];
        bit                pt_valid[PAGE_COUNT];
        logic [PAGE_W-1:0] pt_frame[PAGE_COUNT];
        logic [PAGE_W-1:0] free_frame;
        t_out_item         pending[$];
        int                errors;

        function new();
            free_frame = '0;
            errors     = 0;
            foreach (pt_valid[p]) begin
                pt_valid[p]  = 1'b0;
                page_fill[p] = 0;
            end
        endfunction

        // A page may be translated once it is mapped or fully written
        function bit page_ready(logic [PAGE_W-1:0] pg);
            return pt_valid[pg] || (page_fill[pg] == PAGE_BYTES);
        endfunction

        // Update the mirror for an accepted item; queue the result it causes
        function void note_input(t_in_item it);
            logic [PAGE_W-1:0] pg;
            t_out_item         exp;
            pg = it.address[ADDR_W-1:OFFSET_W];
            if (it.cmd == CMD_LOAD) begin
                if (!written[it.address]) begin
                    written[it.address] = 1'b1;
                    page_fill[pg]++;
                end
                backing[it.address] = it.data;
            end else begin
                exp.page_fault = 1'b0;
                // Fault: copy the whole page into the next free frame
                if (!pt_valid[pg]) begin
                    for (int i = 0; i < PAGE_BYTES; i++)
                        frames[{free_frame, i[OFFSET_W-1:0]}] = backing[{pg, i[OFFSET_W-1:0]}];
                    pt_frame[pg]   = free_frame;
                    pt_valid[pg]   = 1'b1;
                    free_frame     = free_frame + 1'b1;
                    exp.page_fault = 1'b1;
                end
                exp.logical_address  = it.address;
                exp.physical_address = {pt_frame[pg], it.address[OFFSET_W-1:0]};
                exp.value            = frames[exp.physical_address];
                pending.push_back(exp);
            end
        endfunction

        function void compare_field(string name, logic [ADDR_W-1:0] exp, logic [ADDR_W-1:0] got);
            if (exp !== got) begin
                $display("%0t: %s mismatch: expected %h, got %h", $time, name, exp, got);
                errors++;
            end
        endfunction

        // Match a result item against the oldest expectation
        function void check_result(t_out_item got);
            t_out_item exp;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result: expected none, got %h", $time, got);
                errors++;
            end else begin
                exp = pending.pop_front();
                compare_field("logical_address", exp.logical_address, got.logical_address);
                compare_field("physical_address", exp.physical_address, got.physical_address);
                compare_field("value", ADDR_W'(exp.value), ADDR_W'(got.value));
                compare_field("page_fault", ADDR_W'(exp.page_fault), ADDR_W'(got.page_fault));
            end
        endfunction

        // Report results that never arrived
        function void flush_leftovers();
            foreach (pending[i])
                $display("%0t: missing result: expected %h, got none", $time, pending[i]);
            errors += pending.size();
            pending.delete();
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    t_in_item  in_item;
    logic      out_valid;
    logic      out_stall;
    t_out_item out_item;

    xlate_scoreboard sb = new();

    bit          hold_req   = 1'b0;
    bit          tx_no_idle = 1'b0;
    bit          rx_no_idle = 1'b0;
    int unsigned items_sent = 0;
    int unsigned quiet_cycles = 0;
    logic [PAGE_W-1:0] ready_pages[$];

    demand_paging_translator_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    // Clock
    initial clk = 1'b0;
    always #HALF_PERIOD clk = ~clk;

    function automatic int draw_gap(bit no_idle);
        return no_idle ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    // Offer one item after a random gap; hold it until accepted
    task automatic send_item(t_in_item it);
        int gap;
        gap = draw_gap(tx_no_idle);
        repeat (gap) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (in_stall);
        sb.note_input(it);
        items_sent++;
    endtask

    task automatic send_load(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
        t_in_item it;
        it.cmd     = CMD_LOAD;
        it.address = addr;
        it.data    = data;
        send_item(it);
    endtask

    task automatic send_xlate(logic [ADDR_W-1:0] addr);
        t_in_item it;
        it.cmd     = CMD_XLATE;
        it.address = addr;
        it.data    = DATA_W'($urandom);
        send_item(it);
    endtask

    // Write every byte of a page; the first offsets get the extreme bytes
    task automatic fill_page(logic [PAGE_W-1:0] pg);
        logic [DATA_W-1:0] edge_bytes[4];
        logic [DATA_W-1:0] data;
        edge_bytes = '{8'h00, 8'hFF, 8'h80, 8'h7F};
        for (int off = 0; off < PAGE_BYTES; off++) begin
            data = (off < 4) ? edge_bytes[off] : DATA_W'($urandom);
            send_load({pg, off[OFFSET_W-1:0]}, data);
        end
        ready_pages.push_back(pg);
    endtask

    task automatic xlate_ready_page();
        logic [PAGE_W-1:0] pg;
        pg = ready_pages[$urandom_range(0, ready_pages.size() - 1)];
        send_xlate({pg, OFFSET_W'($urandom)});
    endtask

    // Drop valid so the last item is not offered again, then wait for results
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
    endtask

    // Receiver: random stalls, one long hold on request
    initial begin : rx_side
        int wait_n;
        bit hold_now;
        out_stall = 1'b1;
        forever begin
            hold_now = hold_req;
            if ($urandom_range(0, 29) == 0) rx_no_idle = !rx_no_idle;
            wait_n = hold_now ? HOLD_CYCLES : draw_gap(rx_no_idle);
            repeat (wait_n) begin
                @(negedge clk);
                out_stall <= 1'b1;
            end
            if (hold_now) hold_req = 1'b0;
            @(negedge clk);
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    // Check each accepted result item
    always @(posedge clk) begin
        if (out_valid && !out_stall) sb.check_result(out_item);
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Stimulus
    initial begin : tx_side
        int unsigned start_count;
        int unsigned fills;
        int          pick;
        int          burst;
        logic [PAGE_W-1:0] pg;

        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_item  = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: lowest and highest page, extreme bytes and offsets
        fill_page('0);
        fill_page('1);
        send_xlate(16'h0000);           // fault on page zero
        send_xlate(16'h0001);
        send_xlate(16'h0002);
        send_xlate(16'h0003);
        send_xlate(16'h00FF);
        send_load(16'h0001, 8'h55);     // load after page is mapped
        send_xlate(16'h0001);           // frame still holds the old byte
        send_xlate(16'hFFFF);           // fault on the top page
        send_xlate(16'hFF00);
        send_load(16'hFFFF, 8'h00);
        send_xlate(16'hFFFF);
        send_xlate(16'hFF01);

        // Pause the sender until every result is back
        wait_drained();

        // Hold the receiver off while back-to-back items fill the block
        hold_req   = 1'b1;
        tx_no_idle = 1'b1;
        repeat (48) xlate_ready_page();
        tx_no_idle = 1'b0;

        // Random: mostly hits, some new pages, some stray loads
        start_count = items_sent;
        fills       = 0;
        while (items_sent - start_count < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 10) tx_no_idle = !tx_no_idle;
            if (pick < 5 && fills < RANDOM_FILLS) begin
                do pg = PAGE_W'($urandom); while (sb.page_ready(pg));
                fill_page(pg);
                send_xlate({pg, OFFSET_W'($urandom)});
                fills++;
            end else if (pick < 25) begin
                send_load(ADDR_W'($urandom), DATA_W'($urandom));
            end else if (pick < 27) begin
                wait_drained();
            end else begin
                burst = $urandom_range(1, 8);
                repeat (burst) xlate_ready_page();
            end
        end

        // Drop valid, drain and let the tail settle
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        sb.flush_leftovers();
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/dpt_pkg.sv
rtl/dpt_datapath.sv
rtl/dpt_ctrl.sv
rtl/demand_paging_translator_top.sv
tb/sv/demand_paging_translator_top_test.sv
